// File: hw/rtl/qpe_pkg.sv
`timescale 1ns / 1ps

package qpe_pkg;

    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 32;
    localparam int OUT_W      = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int K_W        = 16;
    localparam int KBIT_W     = $clog2(K_W);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_W      = 16;
    localparam int JOBQ_DEPTH = 2;
    localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_PERM_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_K_COUNT   = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        MODE_REVERSE    = 2'd0,
        MODE_ODD        = 2'd1,
        MODE_REV_K      = 2'd2,
        MODE_INTERLEAVE = 2'd3
    } t_mode;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_value;
        logic                    last_out;
        logic                    overflow;
    } t_out_item;

    // store write from the loader
    typedef struct packed {
        logic                         en;
        logic [ADDR_W-1:0]            addr;
        logic signed [WORD_WIDTH-1:0] data;
    } t_wr;

    // one set ready for emission
    typedef struct packed {
        logic [CNT_W-1:0]  n;
        t_mode             mode;
        logic [ADDR_W-1:0] k;
        logic              ovf;
    } t_job;

endpackage

// File: hw/rtl/qpe_front.sv
`timescale 1ns / 1ps

module qpe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  qpe_pkg::t_in_item i_item,
    input  qpe_pkg::t_mode    i_perm_mode,
    input  logic [qpe_pkg::K_W-1:0] i_k_count,
    output qpe_pkg::t_wr      o_wr,
    output logic              o_push,
    output qpe_pkg::t_job     o_job,
    output logic              o_busy
);
    import qpe_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MOD,
        ST_PUSH
    } t_fstate;

    t_fstate           r_state;
    logic [CNT_W-1:0]  r_count;
    logic              r_ovf;
    t_job              r_job;
    logic [K_W-1:0]    r_k;
    logic [CNT_W-1:0]  r_rem;
    logic [KBIT_W-1:0] r_bit;

    logic             w_full;
    logic [CNT_W-1:0] w_n;
    logic [CNT_W:0]   w_shift;
    logic [CNT_W-1:0] n_rem;

    assign w_full = (r_count == CNT_W'(DEPTH));
    assign w_n    = w_full ? r_count : CNT_W'(r_count + CNT_W'(1));

    // one restoring step of k mod n
    assign w_shift = {r_rem, r_k[K_W-1]};
    assign n_rem   = (w_shift >= {1'b0, r_job.n}) ? CNT_W'(w_shift - {1'b0, r_job.n})
                                                  : CNT_W'(w_shift);

    assign o_wr.en   = i_accept && !w_full;
    assign o_wr.addr = r_count[ADDR_W-1:0];
    assign o_wr.data = WORD_WIDTH'(i_item.value);

    assign o_job  = r_job;
    assign o_push = (r_state == ST_PUSH);
    assign o_busy = (r_state != ST_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (i_accept) begin
                        if (i_item.last_in) begin
                            r_job.n    <= w_n;
                            r_job.mode <= i_perm_mode;
                            r_job.ovf  <= r_ovf || w_full;
                            r_job.k    <= '0;
                            r_count    <= '0;
                            r_ovf      <= 1'b0;
                            r_k        <= i_k_count;
                            r_rem      <= '0;
                            r_bit      <= '0;
                            r_state    <= (i_perm_mode == MODE_REV_K) ? ST_MOD : ST_PUSH;
                        end else if (w_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= w_n;
                        end
                    end
                end
                ST_MOD: begin
                    r_rem <= n_rem;
                    r_k   <= {r_k[K_W-2:0], 1'b0};
                    r_bit <= KBIT_W'(r_bit + KBIT_W'(1));
                    if (r_bit == KBIT_W'(K_W - 1)) begin
                        r_job.k <= n_rem[ADDR_W-1:0];
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    r_state <= ST_LOAD;
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> !i_accept)
        else $error("item taken while set in flight");
    a_rem_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOD) |-> (r_rem < r_job.n))
        else $error("remainder out of range");
    a_mod_to_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOD && r_bit == KBIT_W'(K_W - 1)) |=> (r_state == ST_PUSH))
        else $error("remainder unit did not finish");

endmodule

// File: hw/rtl/qpe_job_queue.sv
`timescale 1ns / 1ps

module qpe_job_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qpe_pkg::t_job i_data,
    input  logic          i_pop,
    output qpe_pkg::t_job o_data,
    output logic          o_empty
);
    import qpe_pkg::*;

    t_job               r_mem [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0] r_wp;
    logic [JOBQ_AW-1:0] r_rp;
    logic [JOBQ_AW:0]   r_cnt;

    logic w_full;

    assign w_full  = (r_cnt == (JOBQ_AW + 1)'(JOBQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !w_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !w_full) begin
                r_wp <= (r_wp == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : JOBQ_AW'(r_wp + 1'b1);
            end
            if (i_pop && !o_empty) begin
                r_rp <= (r_rp == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : JOBQ_AW'(r_rp + 1'b1);
            end
            case ({i_push && !w_full, i_pop && !o_empty})
                2'b10:   r_cnt <= (JOBQ_AW + 1)'(r_cnt + 1'b1);
                2'b01:   r_cnt <= (JOBQ_AW + 1)'(r_cnt - 1'b1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !w_full)
        else $error("job queue overrun");
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job queue underrun");
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> !o_empty)
        else $error("pushed job lost");

endmodule

// File: hw/rtl/qpe_back.sv
`timescale 1ns / 1ps

module qpe_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qpe_pkg::t_wr       i_wr,
    input  logic               i_empty,
    input  qpe_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_strobe,
    output qpe_pkg::t_out_item o_result,
    output logic               o_busy
);
    import qpe_pkg::*;

    logic signed [WORD_WIDTH-1:0] r_store [DEPTH];

    logic             r_active;
    t_job             r_job;
    logic [CNT_W-1:0] r_r;
    logic [CNT_W-1:0] r_m;

    logic                         r_v;
    logic                         r_last;
    logic                         r_ovf;
    logic signed [WORD_WIDTH-1:0] r_rd_data;

    logic [CNT_W-1:0] w_idx;
    logic [CNT_W-1:0] w_k;
    logic [CNT_W-1:0] w_h;
    logic [CNT_W-1:0] n_m;
    logic             w_last;

    assign w_k    = CNT_W'(r_job.k);
    assign w_h    = r_job.n >> 1;
    assign n_m    = (i_job.mode == MODE_ODD) ? (i_job.n >> 1) : i_job.n;
    assign w_last = (r_r == CNT_W'(r_m - CNT_W'(1)));
    assign o_pop  = !r_active && !i_empty;

    always_comb begin
        case (r_job.mode)
            MODE_REVERSE: begin
                w_idx = CNT_W'(r_job.n - CNT_W'(1) - r_r);
            end
            MODE_ODD: begin
                w_idx = CNT_W'({r_r[CNT_W-2:0], 1'b1});
            end
            MODE_REV_K: begin
                w_idx = (r_r < w_k) ? CNT_W'(w_k - CNT_W'(1) - r_r) : r_r;
            end
            MODE_INTERLEAVE: begin
                if (r_r < CNT_W'(w_h << 1)) begin
                    w_idx = r_r[0] ? CNT_W'(w_h + (r_r >> 1)) : (r_r >> 1);
                end else begin
                    // odd count: the last element trails
                    w_idx = CNT_W'(r_job.n - CNT_W'(1));
                end
            end
            default: begin
                w_idx = r_r;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[i_wr.addr] <= i_wr.data;
        end
        if (r_active) begin
            r_rd_data <= r_store[w_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_v      <= 1'b0;
        end else begin
            r_v <= r_active;
            if (o_pop) begin
                r_job    <= i_job;
                r_m      <= n_m;
                r_r      <= '0;
                r_active <= (n_m != '0);
            end else if (r_active) begin
                r_last <= w_last;
                r_ovf  <= r_job.ovf;
                r_r    <= CNT_W'(r_r + CNT_W'(1));
                if (w_last) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    assign o_strobe           = r_v;
    assign o_result.out_value = OUT_W'(r_rd_data);
    assign o_result.last_out  = r_last;
    assign o_result.overflow  = r_ovf;
    assign o_busy             = r_active || r_v;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_active)
        else $error("job taken during emission");
    a_idx_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (w_idx < r_job.n))
        else $error("read outside current set");
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v && r_last) |=> !r_v)
        else $error("result after end of run");

endmodule

// File: hw/rtl/queue_permutation_engine_top.sv
`timescale 1ns / 1ps

// Collects a set of signed words, one transfer per cycle while busy is low, and
// emits the set permuted by perm_mode once the item marked last_in is taken.
// Loading runs at one item per clock while busy is low. After the last item,
// busy stays high until the run is out: the set's job passes from the front
// end through the job queue to the emitter, whose reads of the element store
// are registered (in mode 2 a bit-serial unit first reduces k_count mod n);
// then results follow one per clock, set by the single read port of the
// element store. Results carry o_strobe for one cycle and must be taken then;
// there is no backpressure. Items beyond 64 are dropped and the set's results
// carry overflow. Mode 1 on a single element gives no result at all. Write
// configuration only while busy is low and no set is partly loaded.
module queue_permutation_engine_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  qpe_pkg::t_in_item               i_item,
    output logic                            o_strobe,
    output qpe_pkg::t_out_item              o_result,
    input  logic                            i_cfg_we,
    input  logic [qpe_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [qpe_pkg::CFG_W-1:0]       i_cfg_data
);
    import qpe_pkg::*;

    t_mode          r_perm_mode;
    logic [K_W-1:0] r_k_count;

    logic w_accept;
    t_wr  w_wr;
    logic w_push;
    t_job w_job_in;
    t_job w_job_out;
    logic w_pop;
    logic w_empty;
    logic w_front_busy;
    logic w_back_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_mode <= MODE_REVERSE;
            r_k_count   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PERM_MODE: r_perm_mode <= t_mode'(i_cfg_data[1:0]);
                REG_K_COUNT:   r_k_count   <= i_cfg_data[K_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign busy     = w_front_busy || !w_empty || w_back_busy;
    assign w_accept = start && !busy;

    qpe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_item),
        .i_perm_mode (r_perm_mode),
        .i_k_count   (r_k_count),
        .o_wr        (w_wr),
        .o_push      (w_push),
        .o_job       (w_job_in),
        .o_busy      (w_front_busy)
    );

    qpe_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_empty (w_empty)
    );

    qpe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_wr),
        .i_empty  (w_empty),
        .i_job    (w_job_out),
        .o_pop    (w_pop),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .o_busy   (w_back_busy)
    );

endmodule
